/* rtl/iwat_pkg.sv */
package iwat_pkg;

  typedef logic [63:0] word_t;
  typedef logic [1:0]  op_t;
  typedef logic [2:0]  status_t;

  // request codes
  localparam op_t OP_ALLOC  = 2'd0;
  localparam op_t OP_FREE   = 2'd1;
  localparam op_t OP_XLATE  = 2'd2;
  localparam op_t OP_UNUSED = 2'd3;

  // result status codes
  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_NOSPACE = 3'd1;
  localparam status_t ST_OVERLAP = 3'd2;
  localparam status_t ST_NOTHELD = 3'd3;
  localparam status_t ST_FULL    = 3'd4;
  localparam status_t ST_NOXLATE = 3'd5;
  localparam status_t ST_ZERO    = 3'd6;

  localparam word_t ALL_ONES = '1;

  // held window: last is the inclusive end of the virtual range, cut at the top
  typedef struct packed {
    word_t virt;
    word_t io;
    word_t size;
    word_t last;
  } held_ent_t;

  typedef struct packed {
    word_t base;
    word_t size;
  } spare_ent_t;

endpackage

/* rtl/io_window_allocator_translator.sv */
// IO window allocator and translator.
// Input channel (in_valid/in_stall): in_op selects allocate, free or translate;
// in_vaddr and in_len carry the virtual range or address. One result per item
// leaves on the output channel (out_valid/out_stall) as out_io_addr and
// out_status; failures carry all ones.
// Items are handled one at a time. The held table and the spare table sit in
// memories with registered reads. Translate scans the held table; allocate
// and free scan it too, then do a spare scan and an entry shift that together
// visit each spare entry at most once.
// Zero-length allocate and free requests and unused requests skip the scans.
// in_stall stays high while an item is in work, and after reset or after a
// cfg write while the spare table is reloaded with one range.
// The result sits in an output register; while out_stall is high it holds, and
// the next item may be accepted meanwhile; its result waits behind it.
// Reset clears both config registers and empties the tables.
module io_window_allocator_translator #(
  parameter int HELD_ENTRIES  = 32,
  parameter int SPARE_ENTRIES = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  iwat_pkg::word_t  cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  iwat_pkg::op_t    in_op,
  input  iwat_pkg::word_t  in_vaddr,
  input  iwat_pkg::word_t  in_len,
  output logic             out_valid,
  input  logic             out_stall,
  output iwat_pkg::word_t  out_io_addr,
  output iwat_pkg::status_t out_status
);
  import iwat_pkg::*;

  localparam int HW  = (HELD_ENTRIES > 1) ? $clog2(HELD_ENTRIES) : 1;
  localparam int SW  = (SPARE_ENTRIES > 1) ? $clog2(SPARE_ENTRIES) : 1;
  localparam int MX  = (HELD_ENTRIES > SPARE_ENTRIES) ? HELD_ENTRIES : SPARE_ENTRIES;
  localparam int IW  = $clog2(MX + 1);
  localparam int CW  = $clog2(SPARE_ENTRIES + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HRD  = 4'd1;
  localparam logic [3:0] S_HEV  = 4'd2;
  localparam logic [3:0] S_ARD  = 4'd3;
  localparam logic [3:0] S_AEV  = 4'd4;
  localparam logic [3:0] S_AWR  = 4'd5;
  localparam logic [3:0] S_DRD  = 4'd6;
  localparam logic [3:0] S_DEV  = 4'd7;
  localparam logic [3:0] S_FRD  = 4'd8;
  localparam logic [3:0] S_FEV  = 4'd9;
  localparam logic [3:0] S_FDEC = 4'd10;
  localparam logic [3:0] S_URD  = 4'd11;
  localparam logic [3:0] S_UEV  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  // memories
  held_ent_t  held_mem  [HELD_ENTRIES];
  spare_ent_t spare_mem [SPARE_ENTRIES];
  held_ent_t  held_q;
  spare_ent_t spare_q;

  // control and payload registers
  logic [3:0]              state_r, state_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  op_t                     op_r, op_nxt;
  word_t                   va_r, va_nxt;
  word_t                   len_r, len_nxt;
  word_t                   end_r, end_nxt;
  logic [HW-1:0]           slot_r, slot_nxt;
  logic                    slot_ok_r, slot_ok_nxt;
  logic [HW-1:0]           hit_r, hit_nxt;
  word_t                   fb_r, fb_nxt;
  logic [IW-1:0]           p_r, p_nxt;
  spare_ent_t              prev_r, prev_nxt;
  spare_ent_t              cur_r, cur_nxt;
  word_t                   io_r, io_nxt;
  status_t                 st_r, st_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [HELD_ENTRIES-1:0] hvalid_r, hvalid_nxt;
  logic                    reload_r, reload_nxt;
  word_t                   base_r, base_nxt;
  word_t                   size_r, size_nxt;
  logic                    out_valid_r, out_valid_nxt;
  word_t                   out_io_r, out_io_nxt;
  status_t                 out_st_r, out_st_nxt;

  // memory ports
  logic          h_we;
  logic [HW-1:0] h_wa;
  held_ent_t     h_wd;
  logic          s_we;
  logic [SW-1:0] s_wa;
  spare_ent_t    s_wd;
  logic [IW-1:0] s_ra_full;
  logic [SW-1:0] s_ra;

  // derived values
  logic [64:0]   end_sum;
  word_t         neg_base;
  word_t         cut_size;
  logic          hv;
  word_t         x_diff;
  logic [IW-1:0] idx_inc;
  logic [IW-1:0] idx_dec;
  logic [IW-1:0] p_dec;
  logic [IW-1:0] cnt_ext;
  logic          f_left;
  logic          f_right;

  assign end_sum  = {1'b0, in_vaddr} + {1'b0, in_len - 64'd1};
  assign neg_base = ~base_r + 64'd1;
  assign cut_size = (base_r != '0 && size_r > neg_base) ? neg_base : size_r;
  assign hv       = hvalid_r[idx_r[HW-1:0]];
  assign x_diff   = va_r - held_q.virt;
  assign idx_inc  = idx_r + IW'(1);
  assign idx_dec  = idx_r - IW'(1);
  assign p_dec    = p_r - IW'(1);
  assign cnt_ext  = IW'(cnt_r);
  assign f_left   = (p_r != '0) && (prev_r.base + prev_r.size == fb_r);
  assign f_right  = (p_r < cnt_ext) && (fb_r + len_r == cur_r.base);

  // spare read address follows the walk direction
  always_comb begin
    case (state_r)
      S_DRD, S_DEV: s_ra_full = idx_inc;
      S_URD, S_UEV: s_ra_full = idx_dec;
      default:      s_ra_full = idx_r;
    endcase
  end
  assign s_ra = s_ra_full[SW-1:0];

  // memories with registered read
  always_ff @(posedge clk) begin
    if (h_we) begin
      held_mem[h_wa] <= h_wd;
    end
    held_q <= held_mem[idx_r[HW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      spare_mem[s_wa] <= s_wd;
    end
    spare_q <= spare_mem[s_ra];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    va_nxt        = va_r;
    len_nxt       = len_r;
    end_nxt       = end_r;
    slot_nxt      = slot_r;
    slot_ok_nxt   = slot_ok_r;
    hit_nxt       = hit_r;
    fb_nxt        = fb_r;
    p_nxt         = p_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    io_nxt        = io_r;
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    hvalid_nxt    = hvalid_r;
    reload_nxt    = reload_r;
    base_nxt      = base_r;
    size_nxt      = size_r;
    out_valid_nxt = out_valid_r;
    out_io_nxt    = out_io_r;
    out_st_nxt    = out_st_r;
    h_we          = 1'b0;
    h_wa          = slot_r;
    h_wd          = '{virt: va_r, io: cur_r.base, size: len_r, last: end_r};
    s_we          = 1'b0;
    s_wa          = idx_r[SW-1:0];
    s_wd          = spare_q;

    // result taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid && !reload_r) begin
          op_nxt      = in_op;
          va_nxt      = in_vaddr;
          len_nxt     = in_len;
          end_nxt     = end_sum[64] ? ALL_ONES : end_sum[63:0];
          idx_nxt     = '0;
          slot_ok_nxt = 1'b0;
          io_nxt      = ALL_ONES;
          st_nxt      = ST_OK;
          if (in_op == OP_XLATE) begin
            state_nxt = S_HRD;
          end else if (in_op == OP_UNUSED) begin
            st_nxt    = ST_NOXLATE;
            state_nxt = S_DONE;
          end else if (in_len == '0) begin
            st_nxt    = ST_ZERO;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_HRD;
          end
        end
      end

      S_HRD: state_nxt = S_HEV;

      // one held entry per visit
      S_HEV: begin
        state_nxt = S_HRD;
        idx_nxt   = idx_inc;
        if (op_r == OP_XLATE && hv && va_r >= held_q.virt && x_diff < held_q.size) begin
          io_nxt    = held_q.io + x_diff;
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end else if (op_r == OP_ALLOC && hv && va_r <= held_q.last &&
                     held_q.virt <= end_r) begin
          st_nxt    = ST_OVERLAP;
          state_nxt = S_DONE;
        end else if (op_r == OP_FREE && hv && held_q.virt == va_r &&
                     held_q.size == len_r) begin
          hit_nxt   = idx_r[HW-1:0];
          fb_nxt    = held_q.io;
          idx_nxt   = '0;
          state_nxt = S_FRD;
        end else begin
          if (op_r == OP_ALLOC && !hv && !slot_ok_r) begin
            slot_nxt    = idx_r[HW-1:0];
            slot_ok_nxt = 1'b1;
          end
          if (idx_r == IW'(HELD_ENTRIES - 1)) begin
            idx_nxt = '0;
            case (op_r)
              OP_XLATE: begin
                st_nxt    = ST_NOXLATE;
                state_nxt = S_DONE;
              end
              OP_FREE: begin
                st_nxt    = ST_NOTHELD;
                state_nxt = S_DONE;
              end
              default: state_nxt = S_ARD;
            endcase
          end
        end
      end

      // first-fit search over the spare table
      S_ARD: begin
        if (idx_r == cnt_ext) begin
          st_nxt    = ST_NOSPACE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_AEV;
        end
      end

      S_AEV: begin
        if (len_r <= spare_q.size) begin
          cur_nxt = spare_q;
          if (!slot_ok_r) begin
            st_nxt    = ST_FULL;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_AWR;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_ARD;
        end
      end

      // commit allocation: new held entry, shrink the fitting range, drop it if used up
      S_AWR: begin
        h_we             = 1'b1;
        hvalid_nxt[slot_r] = 1'b1;
        s_we             = 1'b1;
        s_wd             = '{base: cur_r.base + len_r, size: cur_r.size - len_r};
        io_nxt           = cur_r.base;
        st_nxt           = ST_OK;
        state_nxt        = (cur_r.size == len_r) ? S_DRD : S_DONE;
      end

      // remove spare entry idx: pull the later entries down by one
      S_DRD: begin
        if ({1'b0, idx_r} + {{IW{1'b0}}, 1'b1} >= {1'b0, cnt_ext}) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DEV;
        end
      end

      S_DEV: begin
        s_we      = 1'b1;
        s_wd      = spare_q;
        idx_nxt   = idx_inc;
        state_nxt = S_DRD;
      end

      // find insertion point of the released range
      S_FRD: begin
        if (idx_r == cnt_ext) begin
          p_nxt     = idx_r;
          state_nxt = S_FDEC;
        end else begin
          state_nxt = S_FEV;
        end
      end

      S_FEV: begin
        if (spare_q.base < fb_r) begin
          prev_nxt  = spare_q;
          idx_nxt   = idx_inc;
          state_nxt = S_FRD;
        end else begin
          cur_nxt   = spare_q;
          p_nxt     = idx_r;
          state_nxt = S_FDEC;
        end
      end

      // merge with neighbors or make room for a new entry
      S_FDEC: begin
        if (f_left || f_right) begin
          st_nxt            = ST_OK;
          io_nxt            = fb_r;
          hvalid_nxt[hit_r] = 1'b0;
          s_we              = 1'b1;
          state_nxt         = S_DONE;
          if (f_left && f_right) begin
            s_wa      = p_dec[SW-1:0];
            s_wd      = '{base: prev_r.base, size: prev_r.size + len_r + cur_r.size};
            idx_nxt   = p_r;
            state_nxt = S_DRD;
          end else if (f_left) begin
            s_wa = p_dec[SW-1:0];
            s_wd = '{base: prev_r.base, size: prev_r.size + len_r};
          end else begin
            s_wa = p_r[SW-1:0];
            s_wd = '{base: fb_r, size: cur_r.size + len_r};
          end
        end else if (cnt_r == CW'(SPARE_ENTRIES)) begin
          st_nxt    = ST_FULL;
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = cnt_ext;
          state_nxt = S_URD;
        end
      end

      // push entries up from the end down to the insertion point
      S_URD: begin
        if (idx_r == p_r) begin
          s_we              = 1'b1;
          s_wa              = p_r[SW-1:0];
          s_wd              = '{base: fb_r, size: len_r};
          cnt_nxt           = cnt_r + CW'(1);
          st_nxt            = ST_OK;
          io_nxt            = fb_r;
          hvalid_nxt[hit_r] = 1'b0;
          state_nxt         = S_DONE;
        end else begin
          state_nxt = S_UEV;
        end
      end

      S_UEV: begin
        s_we      = 1'b1;
        s_wd      = spare_q;
        idx_nxt   = idx_dec;
        state_nxt = S_URD;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_io_nxt    = (st_r == ST_OK) ? io_r : ALL_ONES;
          out_st_nxt    = st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // table reload: one spare range covering the space
    if (reload_r) begin
      reload_nxt = 1'b0;
      hvalid_nxt = '0;
      s_we       = 1'b1;
      s_wa       = '0;
      s_wd       = '{base: base_r, size: cut_size};
      cnt_nxt    = (cut_size != '0) ? CW'(1) : '0;
    end

    // config writes
    if (cfg_we) begin
      if (cfg_index == 1'b0) begin
        base_nxt = cfg_wdata;
      end else begin
        size_nxt = cfg_wdata;
      end
      reload_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      slot_ok_r   <= 1'b0;
      cnt_r       <= '0;
      hvalid_r    <= '0;
      reload_r    <= 1'b1;
      base_r      <= '0;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      slot_ok_r   <= slot_ok_nxt;
      cnt_r       <= cnt_nxt;
      hvalid_r    <= hvalid_nxt;
      reload_r    <= reload_nxt;
      base_r      <= base_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    va_r     <= va_nxt;
    len_r    <= len_nxt;
    end_r    <= end_nxt;
    slot_r   <= slot_nxt;
    hit_r    <= hit_nxt;
    fb_r     <= fb_nxt;
    p_r      <= p_nxt;
    prev_r   <= prev_nxt;
    cur_r    <= cur_nxt;
    io_r     <= io_nxt;
    st_r     <= st_nxt;
    out_io_r <= out_io_nxt;
    out_st_r <= out_st_nxt;
  end

  assign in_stall    = (state_r != S_IDLE) || reload_r;
  assign out_valid   = out_valid_r;
  assign out_io_addr = out_io_r;
  assign out_status  = out_st_r;

endmodule

/* rtl/iwat_checker.sv */
module iwat_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_we,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input iwat_pkg::word_t    out_io_addr,
  input iwat_pkg::status_t  out_status
);
  import iwat_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_io_addr) && $stable(out_status))
    else $error("result changed while stalled");

  // failures carry all ones
  a_fail_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_io_addr == ALL_ONES)
    else $error("failed result without all-ones address");

  // status code in range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_ZERO)
    else $error("status code out of range");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // a cfg write blocks input for the table reload
  a_reload_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input open during table reload");

endmodule

bind io_window_allocator_translator iwat_checker u_iwat_checker (.*);

/* dv/iwat_checker.sv */
`timescale 1ns / 1ps

module iwat_scoreboard #(
  parameter int HELD_ENTRIES  = 32,
  parameter int SPARE_ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  iwat_pkg::word_t   cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  iwat_pkg::op_t     in_op,
  input  iwat_pkg::word_t   in_vaddr,
  input  iwat_pkg::word_t   in_len,
  input  logic              out_valid,
  input  logic              out_stall,
  input  iwat_pkg::word_t   out_io_addr,
  input  iwat_pkg::status_t out_status,
  output int                fail_count,
  output int                pending
);
  import iwat_pkg::*;

  typedef struct packed {
    word_t   io_addr;
    status_t status;
  } answer_t;

  word_t   win_base, win_size;
  logic    hv [HELD_ENTRIES];
  word_t   hvirt [HELD_ENTRIES];
  word_t   hio [HELD_ENTRIES];
  word_t   hsize [HELD_ENTRIES];
  logic    sv [SPARE_ENTRIES];
  word_t   sbase [SPARE_ENTRIES];
  word_t   ssize [SPARE_ENTRIES];
  answer_t answers_due [$];

  assign pending = answers_due.size();

  function automatic word_t range_last(word_t b, word_t n);
    if (n - 1 > ALL_ONES - b) return ALL_ONES;
    return b + (n - 1);
  endfunction

  function automatic void reload_space();
    word_t sz;
    sz = win_size;
    for (int i = 0; i < HELD_ENTRIES; i++) begin
      hv[i] = 0; hvirt[i] = 0; hio[i] = 0; hsize[i] = 0;
    end
    for (int i = 0; i < SPARE_ENTRIES; i++) begin
      sv[i] = 0; sbase[i] = 0; ssize[i] = 0;
    end
    if (win_base != 0 && sz > word_t'(0) - win_base) sz = word_t'(0) - win_base;
    if (sz != 0) begin
      sv[0] = 1; sbase[0] = win_base; ssize[0] = sz;
    end
  endfunction

  function automatic int spare_used();
    int n;
    n = 0;
    while (n < SPARE_ENTRIES && sv[n]) n++;
    return n;
  endfunction

  function automatic void spare_drop(int i, int cnt);
    for (int j = i; j + 1 < cnt; j++) begin
      sbase[j] = sbase[j+1]; ssize[j] = ssize[j+1];
    end
    if (cnt > 0) begin
      sv[cnt-1] = 0; sbase[cnt-1] = 0; ssize[cnt-1] = 0;
    end
  endfunction

  function automatic status_t alloc_window(word_t va, word_t n, output word_t io);
    int slot, fit, cnt;
    word_t last, hl, lo, hi;
    slot = HELD_ENTRIES; fit = SPARE_ENTRIES;
    io = ALL_ONES;
    last = range_last(va, n);
    for (int i = 0; i < HELD_ENTRIES; i++) begin
      if (hv[i]) begin
        hl = range_last(hvirt[i], hsize[i]);
        lo = va > hvirt[i] ? va : hvirt[i];
        hi = last < hl ? last : hl;
        if (lo <= hi) return ST_OVERLAP;
      end else if (slot == HELD_ENTRIES) begin
        slot = i;
      end
    end
    cnt = spare_used();
    for (int i = 0; i < cnt; i++) begin
      if (n <= ssize[i]) begin
        fit = i;
        break;
      end
    end
    if (fit == SPARE_ENTRIES) return ST_NOSPACE;
    if (slot == HELD_ENTRIES) return ST_FULL;
    hv[slot] = 1; hvirt[slot] = va; hio[slot] = sbase[fit]; hsize[slot] = n;
    io = sbase[fit];
    sbase[fit] += n;
    ssize[fit] -= n;
    if (ssize[fit] == 0) spare_drop(fit, cnt);
    return ST_OK;
  endfunction

  function automatic status_t free_window(word_t va, word_t n, output word_t io);
    int h, cnt, p;
    word_t fb, fs;
    logic left, right;
    h = HELD_ENTRIES;
    io = ALL_ONES;
    for (int i = 0; i < HELD_ENTRIES; i++) begin
      if (hv[i] && hvirt[i] == va && hsize[i] == n) begin
        h = i;
        break;
      end
    end
    if (h == HELD_ENTRIES) return ST_NOTHELD;
    fb = hio[h]; fs = hsize[h];
    cnt = spare_used();
    p = 0;
    while (p < cnt && sbase[p] < fb) p++;
    left  = p > 0 && sbase[p-1] + ssize[p-1] == fb;
    right = p < cnt && fb + fs == sbase[p];
    if (left && right) begin
      ssize[p-1] += fs + ssize[p];
      spare_drop(p, cnt);
    end else if (left) begin
      ssize[p-1] += fs;
    end else if (right) begin
      sbase[p] = fb;
      ssize[p] += fs;
    end else begin
      if (cnt >= SPARE_ENTRIES) return ST_FULL;
      for (int i = cnt; i > p; i--) begin
        sbase[i] = sbase[i-1]; ssize[i] = ssize[i-1];
      end
      sv[cnt] = 1; sbase[p] = fb; ssize[p] = fs;
    end
    hv[h] = 0; hvirt[h] = 0; hio[h] = 0; hsize[h] = 0;
    io = fb;
    return ST_OK;
  endfunction

  function automatic answer_t predict_answer(op_t op, word_t va, word_t n);
    answer_t a;
    word_t io;
    io = ALL_ONES;
    a.status = ST_NOXLATE;
    if (op == OP_XLATE) begin
      for (int i = 0; i < HELD_ENTRIES; i++) begin
        if (hv[i] && va >= hvirt[i] && va - hvirt[i] < hsize[i]) begin
          io = hio[i] + (va - hvirt[i]);
          a.status = ST_OK;
          break;
        end
      end
    end else if (op == OP_UNUSED) begin
      a.status = ST_NOXLATE;
    end else if (n == 0) begin
      a.status = ST_ZERO;
    end else if (op == OP_ALLOC) begin
      a.status = alloc_window(va, n, io);
    end else begin
      a.status = free_window(va, n, io);
    end
    a.io_addr = (a.status == ST_OK) ? io : ALL_ONES;
    return a;
  endfunction

  // track config, predict on input accept, compare on output accept
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      win_base = 0; win_size = 0;
      reload_space();
      answers_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'b0) win_base = cfg_wdata;
        else win_size = cfg_wdata;
        reload_space();
      end
      if (in_valid && !in_stall)
        answers_due.push_back(predict_answer(in_op, in_vaddr, in_len));
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected item io_addr=%h status=%0d", $time,
                   out_io_addr, out_status);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (out_io_addr !== want.io_addr) begin
            $display("%0t: io_addr expected %h actual %h", $time, want.io_addr,
                     out_io_addr);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_status);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

/* dv/io_window_allocator_translator_tb.sv */
`timescale 1ns / 1ps

module io_window_allocator_translator_tb;
  import iwat_pkg::*;

  logic    clk = 0;
  logic    rst_n = 0;
  logic    cfg_we = 0;
  logic [0:0] cfg_index = 1'b0;
  word_t   cfg_wdata = 0;
  logic    in_valid = 0;
  logic    in_stall;
  op_t     in_op = OP_ALLOC;
  word_t   in_vaddr = 0;
  word_t   in_len = 0;
  logic    out_valid;
  logic    out_stall = 0;
  word_t   out_io_addr;
  status_t out_status;
  int      fail_count, pending;

  // windows handed out, kept so frees and translates can hit them
  word_t   live_va [$];
  word_t   live_len [$];
  word_t   va_cursor;

  always #5 clk = ~clk;

  io_window_allocator_translator DUT (.*);

  iwat_scoreboard u_scoreboard (.*);

  // random output stall, redrawn per item
  initial begin
    int hold;
    @(posedge clk iff rst_n);
    forever begin
      hold = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) hold = 0;
      repeat (hold) begin
        out_stall <= 1;
        @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk iff out_valid);
    end
  end

  // valid drops only when a gap follows; the next call or settle() lowers it
  task automatic send_item(op_t op, word_t va, word_t n);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_op <= op; in_vaddr <= va; in_len <= n;
    @(posedge clk iff !in_stall);
  endtask

  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * 32 + 4 * 32 + 20) @(posedge clk);
  endtask

  task automatic set_space(word_t base, word_t size);
    settle();
    cfg_we <= 1; cfg_index <= 1'b0; cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= 1'b1; cfg_wdata <= size;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    live_va.delete(); live_len.delete();
    va_cursor = word_t'($urandom) << 20;
  endtask

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(int count, word_t scale);
    int k, pick;
    word_t n;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        n = word_t'($urandom_range(1, int'(scale)));
        if ($urandom_range(0, 9) == 0) n = rand_word();
        send_item(OP_ALLOC, va_cursor, n);
        live_va.push_back(va_cursor); live_len.push_back(n);
        va_cursor += n + $urandom_range(0, 64);
      end else if (pick < 65 && live_va.size() > 0) begin
        k = $urandom_range(0, live_va.size() - 1);
        send_item(OP_FREE, live_va[k], live_len[k]);
        live_va.delete(k); live_len.delete(k);
      end else if (pick < 85 && live_va.size() > 0) begin
        k = $urandom_range(0, live_va.size() - 1);
        send_item(OP_XLATE, live_va[k] + $urandom_range(0, live_len[k] - 1 < 300 ?
                  live_len[k] - 1 : 300), rand_word());
      end else begin
        send_item(op_t'($urandom_range(0, 3)), rand_word(),
                  $urandom_range(0, 1) ? rand_word() : word_t'($urandom_range(0, 2)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // empty space after reset
    send_item(OP_ALLOC, 64'h1000, 64'h10);
    send_item(OP_XLATE, 64'h1000, 0);
    send_item(OP_FREE, 64'h1000, 64'h10);
    send_item(OP_UNUSED, ALL_ONES, ALL_ONES);

    // space cut at the top, ranges past the top
    set_space(64'hFFFF_FFFF_FFFF_F000, ALL_ONES);
    send_item(OP_ALLOC, 64'h0, 0);
    send_item(OP_FREE, 64'h0, 0);
    send_item(OP_ALLOC, 64'hFFFF_FFFF_FFFF_FF00, ALL_ONES);
    send_item(OP_ALLOC, 64'hFFFF_FFFF_FFFF_FF00, 64'h100);
    send_item(OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFF0, 64'h8);
    send_item(OP_XLATE, ALL_ONES, 0);
    send_item(OP_XLATE, 64'h0, 0);
    send_item(OP_ALLOC, 64'h0, 64'h2000);
    send_item(OP_ALLOC, 64'h0, 64'hF00);
    send_item(OP_FREE, 64'h0, 64'hF01);
    send_item(OP_FREE, 64'hFFFF_FFFF_FFFF_FF00, 64'h100);
    send_item(OP_FREE, 64'h0, 64'hF00);

    // small space: fill the held table, then fragment the spare table
    set_space(64'h1000, 64'd4096);
    for (int i = 0; i < 33; i++) send_item(OP_ALLOC, 64'h10000 + i * 64, 64);
    for (int i = 0; i < 32; i += 2) send_item(OP_FREE, 64'h10000 + i * 64, 64);
    send_item(OP_FREE, 64'h10000 + 31 * 64, 64);
    send_item(OP_ALLOC, 64'h90000, 64);

    // sender holds off until all results are back
    settle();

    set_space(0, ALL_ONES);
    random_phase(130, 4096);
    set_space(64'h4000, 64'd2048);
    random_phase(130, 256);
    set_space(rand_word(), rand_word());
    random_phase(130, 1 << 16);

    settle();
    if (fail_count == 0) begin
      $display("** io_window_allocator_translator: PASSED **");
    end else begin
      $display("** io_window_allocator_translator: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** io_window_allocator_translator: FAILED **");
    $finish;
  end

endmodule
